// ===== rtl/core/pvc_pkg.sv =====
// ============================================================================
// pvc_pkg: shared types and constants of the proportional velocity clamp
// Request payloads, register indexes, reset values and pipeline depths.
// ============================================================================
`default_nettype none

package pvc_pkg;

  localparam int Q_W        = 32;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 23;
  localparam int SQ_W       = 2 * Q_W;
  localparam int NUM_W      = Q_W + LIM_W;
  localparam int SQRT_STEPS = Q_W;
  localparam int DIV_STEPS  = LIM_W;
  localparam int IDX_W      = 3;

  typedef enum logic [IDX_W-1:0] {
    CFG_MODE        = 3'd0,
    CFG_GAIN_XY     = 3'd1,
    CFG_SPEED_LIMIT = 3'd2,
    CFG_GAIN_Z      = 3'd3,
    CFG_Z_LIMIT     = 3'd4
  } pvc_cfg_idx_t;

  localparam logic              MODE_RST        = 1'b1;
  localparam logic [GAIN_W-1:0] GAIN_XY_RST     = 16'd1024;
  localparam logic [LIM_W-1:0]  SPEED_LIMIT_RST = 23'd65536;
  localparam logic [GAIN_W-1:0] GAIN_Z_RST      = 16'd384;
  localparam logic [LIM_W-1:0]  Z_LIMIT_RST     = 23'd65536;

  typedef struct packed {
    logic signed [Q_W-1:0] cur_x;
    logic signed [Q_W-1:0] cur_y;
    logic signed [Q_W-1:0] cur_z;
    logic signed [Q_W-1:0] target_x;
    logic signed [Q_W-1:0] target_y;
    logic signed [Q_W-1:0] target_z;
  } pvc_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] vel_x;
    logic signed [Q_W-1:0] vel_y;
    logic signed [Q_W-1:0] vel_z;
    logic [Q_W-1:0]        error_norm;
  } pvc_out_t;

  typedef struct packed {
    logic              mode;
    logic [GAIN_W-1:0] gain_xy;
    logic [LIM_W-1:0]  speed_limit;
    logic [GAIN_W-1:0] gain_z;
    logic [LIM_W-1:0]  z_limit;
  } pvc_cfg_t;

  // Per-request values that ride alongside the square root and divide units.
  typedef struct packed {
    logic           sgn_x;
    logic           sgn_y;
    logic           sgn_z;
    logic [Q_W-1:0] mag_x;
    logic [Q_W-1:0] mag_y;
    logic [Q_W-1:0] mag_z;
    logic           hit;
    logic           ovf;
  } pvc_side_t;

endpackage

`default_nettype wire

// ===== rtl/core/pvc_front.sv =====
// ============================================================================
// pvc_front: error, gain, saturation, squares and limit test
// Five register stages from the position request to the squared speed.
// ============================================================================
`default_nettype none

module pvc_front import pvc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  pvc_in_t          in_data,
  input  pvc_cfg_t         cfg,
  output logic             valid_o,
  output pvc_side_t        side_o,
  output logic [SQ_W-1:0]  s_o,
  output logic [SQ_W-1:0]  es_o
);

  localparam int RND_W = Q_W + GAIN_W - 8 + 1;
  localparam logic [RND_W-1:0] POS_MAX = RND_W'(64'h7FFF_FFFF);
  localparam logic [RND_W-1:0] NEG_MAX = RND_W'(64'h8000_0000);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  logic [Q_W:0]            e_r    [3];
  logic [Q_W:0]            neg_e  [3];
  logic [Q_W-1:0]          mag_e  [3];
  logic [Q_W+GAIN_W-1:0]   p_r    [3];
  logic [SQ_W-1:0]         esq_r  [3];
  logic                    sgn2_r [3];
  logic [RND_W+7:0]        rnd_full [3];
  logic [RND_W-1:0]        rnd    [3];
  logic [Q_W-1:0]          sat    [3];
  logic [Q_W-1:0]          mag3_r [3];
  logic                    sgn3_r [3];
  logic [SQ_W+1:0]         esum;
  logic [SQ_W-1:0]         es3_r, es4_r;
  logic                    ovf3_r, ovf4_r;
  logic [SQ_W-1:0]         sq4_r  [3];
  logic [Q_W-1:0]          mag4_r [3];
  logic                    sgn4_r [3];
  logic [SQ_W-1:0]         ssum;
  logic [2*LIM_W-1:0]      lim_sq_r;
  logic [GAIN_W-1:0]       gain_z_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    lim_sq_r <= cfg.speed_limit * cfg.speed_limit;
  end

  // Stage 1: exact 33-bit position error.
  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= {in_data.target_x[Q_W-1], in_data.target_x} -
                {in_data.cur_x[Q_W-1], in_data.cur_x};
      e_r[1] <= {in_data.target_y[Q_W-1], in_data.target_y} -
                {in_data.cur_y[Q_W-1], in_data.cur_y};
      e_r[2] <= {in_data.target_z[Q_W-1], in_data.target_z} -
                {in_data.cur_z[Q_W-1], in_data.cur_z};
    end
  end

  // Stage 2: gain products and error squares.
  assign gain_z_sel = cfg.mode ? cfg.gain_z : cfg.gain_xy;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_e[i] = (Q_W+1)'(0) - e_r[i];
      mag_e[i] = e_r[i][Q_W] ? neg_e[i][Q_W-1:0] : e_r[i][Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= mag_e[0] * cfg.gain_xy;
      p_r[1] <= mag_e[1] * cfg.gain_xy;
      p_r[2] <= mag_e[2] * gain_z_sel;
      for (int i = 0; i < 3; i++) begin
        esq_r[i]  <= mag_e[i] * mag_e[i];
        sgn2_r[i] <= e_r[i][Q_W];
      end
    end
  end

  // Stage 3: round half away from zero, saturate, sum error squares.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd_full[i] = ({1'b0, p_r[i]} + (RND_W+8)'(128));
      rnd[i]      = rnd_full[i][RND_W+7:8];
      if (sgn2_r[i]) begin
        sat[i] = (rnd[i] > NEG_MAX) ? NEG_MAX[Q_W-1:0] : rnd[i][Q_W-1:0];
      end else begin
        sat[i] = (rnd[i] > POS_MAX) ? POS_MAX[Q_W-1:0] : rnd[i][Q_W-1:0];
      end
    end
    esum = {2'b00, esq_r[0]} + {2'b00, esq_r[1]} +
           (cfg.mode ? (SQ_W+2)'(0) : {2'b00, esq_r[2]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag3_r[i] <= sat[i];
        sgn3_r[i] <= sgn2_r[i];
      end
      es3_r  <= esum[SQ_W-1:0];
      ovf3_r <= |esum[SQ_W+1:SQ_W];
    end
  end

  // Stage 4: squares of the velocity magnitudes.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4_r[i]  <= mag3_r[i] * mag3_r[i];
        mag4_r[i] <= mag3_r[i];
        sgn4_r[i] <= sgn3_r[i];
      end
      es4_r  <= es3_r;
      ovf4_r <= ovf3_r;
    end
  end

  // Stage 5: squared speed and the limit test. The sum cannot overflow.
  assign ssum = sq4_r[0] + sq4_r[1] + (cfg.mode ? SQ_W'(0) : sq4_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      side_o.sgn_x <= sgn4_r[0];
      side_o.sgn_y <= sgn4_r[1];
      side_o.sgn_z <= sgn4_r[2];
      side_o.mag_x <= mag4_r[0];
      side_o.mag_y <= mag4_r[1];
      side_o.mag_z <= mag4_r[2];
      side_o.hit   <= ssum > SQ_W'(lim_sq_r);
      side_o.ovf   <= ovf4_r;
      s_o          <= ssum;
      es_o         <= es4_r;
    end
  end

  assign valid_o = v5_r;

endmodule

`default_nettype wire

// ===== rtl/core/pvc_isqrt.sv =====
// ============================================================================
// pvc_isqrt: pipelined integer square root
// One root bit per stage, floor of the square root of a 64-bit radicand.
// ============================================================================
`default_nettype none

module pvc_isqrt import pvc_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [SQ_W-1:0] rad,
  output logic [Q_W-1:0]  root
);

  localparam int REM_W = Q_W + 3;

  logic [REM_W-1:0] rem_r  [SQRT_STEPS-1];
  logic [SQ_W-1:0]  rad_r  [SQRT_STEPS-1];
  logic [Q_W-1:0]   root_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [REM_W-1:0] rem_in;
    logic [SQ_W-1:0]  rad_in;
    logic [Q_W-1:0]   root_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = rad;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], rad_in[SQ_W-1:SQ_W-2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_in[Q_W-2:0], take};
      end
    end

    if (k < SQRT_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? (rem_sh - trial) : rem_sh;
          rad_r[k] <= {rad_in[SQ_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_r[SQRT_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/core/pvc_div.sv =====
// ============================================================================
// pvc_div: pipelined restoring divider
// One quotient bit per stage; the quotient is known to fit the limit width.
// ============================================================================
`default_nettype none

module pvc_div import pvc_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [Q_W-1:0]   den,
  output logic [LIM_W-1:0] quo
);

  logic [Q_W-1:0]   rem_r [DIV_STEPS-1];
  logic [Q_W-1:0]   den_r [DIV_STEPS-1];
  logic [LIM_W-1:0] low_r [DIV_STEPS-1];
  logic [LIM_W-1:0] quo_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [Q_W-1:0]   rem_in;
    logic [Q_W-1:0]   den_in;
    logic [LIM_W-1:0] low_in;
    logic [LIM_W-1:0] quo_in;
    logic [Q_W:0]     rem_sh;
    logic [Q_W:0]     diff;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in = num[NUM_W-1:LIM_W];
      assign den_in = den;
      assign low_in = num[LIM_W-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign low_in = low_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign rem_sh = {rem_in, low_in[LIM_W-1]};
    assign diff   = rem_sh - {1'b0, den_in};
    assign take   = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= {quo_in[LIM_W-2:0], take};
      end
    end

    if (k < DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? diff[Q_W-1:0] : rem_sh[Q_W-1:0];
          den_r[k] <= den_in;
          low_r[k] <= {low_in[LIM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_r[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/core/proportional_velocity_clamp.sv =====
// ============================================================================
// proportional_velocity_clamp: P controller with speed norm limiting
// Position error times gain, vector norm limiting and error norm output.
// ============================================================================
//
//   Channel  Handshake            Payload     Role
//   in_      in_valid/in_ready    pvc_in_t    current and target position
//   out_     out_valid/out_ready  pvc_out_t   velocity command, error norm
//   cfg_     cfg_we               cfg_index,  register write, no wait
//                                 cfg_wdata
//
// One request enters per cycle while the output queue has a free entry. A
// request passes through five front stages, 32 square-root stages (one root
// bit each), one multiply stage and 23 divide stages (one quotient bit
// each), and is then written into a two-entry output queue. The whole
// pipeline advances on one enable that is high while the queue has a free
// entry, so a stalled output holds every stage and nothing is lost or
// repeated. Reset is synchronous and active low; it clears the valid bits,
// the queue and the configuration registers.
`default_nettype none

module proportional_velocity_clamp import pvc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pvc_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pvc_out_t         out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [LIM_W-1:0] cfg_wdata
);

  // Configuration registers.
  pvc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= MODE_RST;
      cfg_r.gain_xy     <= GAIN_XY_RST;
      cfg_r.speed_limit <= SPEED_LIMIT_RST;
      cfg_r.gain_z      <= GAIN_Z_RST;
      cfg_r.z_limit     <= Z_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:        cfg_r.mode        <= cfg_wdata[0];
        CFG_GAIN_XY:     cfg_r.gain_xy     <= cfg_wdata[GAIN_W-1:0];
        CFG_SPEED_LIMIT: cfg_r.speed_limit <= cfg_wdata;
        CFG_GAIN_Z:      cfg_r.gain_z      <= cfg_wdata[GAIN_W-1:0];
        CFG_Z_LIMIT:     cfg_r.z_limit     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves while the output queue has room.
  logic [1:0] cnt_r;
  logic       en;
  logic       push;
  logic       pop;

  assign en       = (cnt_r != 2'd2);
  assign in_ready = en;

  // Front stages: error, gain, saturation, squares and the limit test.
  logic            f_valid;
  pvc_side_t       f_side;
  logic [SQ_W-1:0] f_s;
  logic [SQ_W-1:0] f_es;

  pvc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .valid_o  (f_valid),
    .side_o   (f_side),
    .s_o      (f_s),
    .es_o     (f_es)
  );

  // Square roots of the squared speed and of the squared error run side by
  // side, with the request's other values delayed to match.
  logic [Q_W-1:0] root_v;
  logic [Q_W-1:0] root_e;

  pvc_isqrt u_sqrt_vel (
    .clk  (clk),
    .en   (en),
    .rad  (f_s),
    .root (root_v)
  );

  pvc_isqrt u_sqrt_err (
    .clk  (clk),
    .en   (en),
    .rad  (f_es),
    .root (root_e)
  );

  logic      a_valid_r [SQRT_STEPS];
  pvc_side_t a_side_r  [SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        a_valid_r[k] <= 1'b0;
      end
    end else if (en) begin
      a_valid_r[0] <= f_valid;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        a_valid_r[k] <= a_valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r[0] <= f_side;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        a_side_r[k] <= a_side_r[k-1];
      end
    end
  end

  // Multiply stage: each magnitude times the speed limit forms the dividend
  // of the rescale, the speed norm is the divisor.
  logic             m_valid_r;
  pvc_side_t        m_side_r;
  logic [Q_W-1:0]   m_norm_r;
  logic [Q_W-1:0]   m_den_r;
  logic [NUM_W-1:0] m_num_x_r;
  logic [NUM_W-1:0] m_num_y_r;
  logic [NUM_W-1:0] m_num_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= a_valid_r[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_side_r  <= a_side_r[SQRT_STEPS-1];
      m_norm_r  <= root_e;
      m_den_r   <= root_v;
      m_num_x_r <= a_side_r[SQRT_STEPS-1].mag_x * cfg_r.speed_limit;
      m_num_y_r <= a_side_r[SQRT_STEPS-1].mag_y * cfg_r.speed_limit;
      m_num_z_r <= a_side_r[SQRT_STEPS-1].mag_z * cfg_r.speed_limit;
    end
  end

  // Three dividers rescale the components onto the limit. When the limit
  // is hit the norm is at least as large as every component, so each
  // quotient fits the limit width.
  logic [LIM_W-1:0] q_x;
  logic [LIM_W-1:0] q_y;
  logic [LIM_W-1:0] q_z;

  pvc_div u_div_x (.clk(clk), .en(en), .num(m_num_x_r), .den(m_den_r), .quo(q_x));
  pvc_div u_div_y (.clk(clk), .en(en), .num(m_num_y_r), .den(m_den_r), .quo(q_y));
  pvc_div u_div_z (.clk(clk), .en(en), .num(m_num_z_r), .den(m_den_r), .quo(q_z));

  logic           b_valid_r [DIV_STEPS];
  pvc_side_t      b_side_r  [DIV_STEPS];
  logic [Q_W-1:0] b_norm_r  [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        b_valid_r[k] <= 1'b0;
      end
    end else if (en) begin
      b_valid_r[0] <= m_valid_r;
      for (int k = 1; k < DIV_STEPS; k++) begin
        b_valid_r[k] <= b_valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side_r[0] <= m_side_r;
      b_norm_r[0] <= m_norm_r;
      for (int k = 1; k < DIV_STEPS; k++) begin
        b_side_r[k] <= b_side_r[k-1];
        b_norm_r[k] <= b_norm_r[k-1];
      end
    end
  end

  // Final selection: the scaled or the plain magnitude, the separate Z clamp
  // in XY mode, the sign restored, and the error norm forced to all ones on overflow.
  pvc_side_t      fin_side;
  logic [Q_W-1:0] lim_w;
  logic [Q_W-1:0] zlim_w;
  logic [Q_W-1:0] sc_x, sc_y, sc_z;
  logic [Q_W-1:0] fm_x, fm_y, fm_z;
  pvc_out_t       fin;

  assign fin_side = b_side_r[DIV_STEPS-1];
  assign lim_w    = Q_W'(cfg_r.speed_limit);
  assign zlim_w   = Q_W'(cfg_r.z_limit);

  always_comb begin
    sc_x = (Q_W'(q_x) > lim_w) ? lim_w : Q_W'(q_x);
    sc_y = (Q_W'(q_y) > lim_w) ? lim_w : Q_W'(q_y);
    sc_z = (Q_W'(q_z) > lim_w) ? lim_w : Q_W'(q_z);
    fm_x = fin_side.hit ? sc_x : fin_side.mag_x;
    fm_y = fin_side.hit ? sc_y : fin_side.mag_y;
    if (cfg_r.mode) begin
      fm_z = (fin_side.mag_z > zlim_w) ? zlim_w : fin_side.mag_z;
    end else begin
      fm_z = fin_side.hit ? sc_z : fin_side.mag_z;
    end
    fin.vel_x      = fin_side.sgn_x ? (Q_W'(0) - fm_x) : fm_x;
    fin.vel_y      = fin_side.sgn_y ? (Q_W'(0) - fm_y) : fm_y;
    fin.vel_z      = fin_side.sgn_z ? (Q_W'(0) - fm_z) : fm_z;
    fin.error_norm = fin_side.ovf ? '1 : b_norm_r[DIV_STEPS-1];
  end

  // Two-entry output queue decouples the pipeline from the result channel.
  pvc_out_t ent_r [2];
  logic     wr_ptr_r;
  logic     rd_ptr_r;

  assign push      = en && b_valid_r[DIV_STEPS-1];
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= fin;
    end
  end

  // The queue never holds more than two results.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("output queue overfilled");

  // A push without a pop grows the queue by one.
  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("output queue count missed a push");

  // A stall freezes the last stage, so no result is dropped or repeated.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(b_valid_r[DIV_STEPS-1]))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// ===== tb/sv/tb_proportional_velocity_clamp.sv =====
// ============================================================================
// tb_proportional_velocity_clamp: self-checking bench for the velocity clamp
// Drives position requests through the valid/ready channel, predicts every
// velocity command and error norm in fixed point, and compares field by field.
// ============================================================================
`default_nettype none

module tb_proportional_velocity_clamp;
  import pvc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The pipeline is 61 stages deep plus a two-entry queue.
  localparam int PIPE_DEPTH = 70;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  pvc_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  pvc_out_t         out_data;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [LIM_W-1:0] cfg_wdata;

  proportional_velocity_clamp u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the register file, updated on every write we issue to a defined register.
  pvc_cfg_t  shadow_cfg;
  pvc_out_t  pending_cmds[$];
  int        error_count;
  bit        idle_enabled;
  int        hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Absolute limit on the run; a hang is a failure.
  initial begin
    #5ms;
    $display("proportional_velocity_clamp verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Error times Q8.8 gain: magnitude rounded half away from zero, then saturated.
  function automatic longint gain_product(input longint err, input logic [15:0] gain);
    logic [63:0] mag;
    mag = ((err < 0 ? -err : err) * longint'(gain) + 128) >> 8;
    if (err < 0) return (mag > 64'd2147483648) ? -64'sd2147483648 : -longint'(mag);
    return (mag > 64'd2147483647) ? 64'sd2147483647 : longint'(mag);
  endfunction

  function automatic longint scale_component(input longint v, input logic [63:0] lim,
                                             input logic [63:0] n);
    logic [63:0] mag;
    mag = (v < 0 ? -v : v) * lim / n;
    if (mag > lim) mag = lim;
    return v < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic pvc_out_t predict_command(input pvc_in_t req);
    longint      ex, ey, ez, vx, vy, vz, zl;
    logic [63:0] lim, sum_sq, norm, a, b, c, es, t;
    bit          ovf;
    pvc_out_t    res;
    ex  = longint'(req.target_x) - longint'(req.cur_x);
    ey  = longint'(req.target_y) - longint'(req.cur_y);
    ez  = longint'(req.target_z) - longint'(req.cur_z);
    lim = 64'(shadow_cfg.speed_limit);
    vx  = gain_product(ex, shadow_cfg.gain_xy);
    vy  = gain_product(ey, shadow_cfg.gain_xy);
    if (shadow_cfg.mode == 1'b0) begin
      vz = gain_product(ez, shadow_cfg.gain_xy);
      sum_sq = vx * vx + vy * vy + vz * vz;
      if (sum_sq > lim * lim) begin
        norm = isqrt(sum_sq);
        vx = scale_component(vx, lim, norm);
        vy = scale_component(vy, lim, norm);
        vz = scale_component(vz, lim, norm);
      end
    end else begin
      zl = longint'(shadow_cfg.z_limit);
      sum_sq = vx * vx + vy * vy;
      if (sum_sq > lim * lim) begin
        norm = isqrt(sum_sq);
        vx = scale_component(vx, lim, norm);
        vy = scale_component(vy, lim, norm);
      end
      vz = gain_product(ez, shadow_cfg.gain_z);
      if (vz > zl) vz = zl;
      if (vz < -zl) vz = -zl;
    end
    // The error squares use unsigned 64-bit wraparound to detect overflow.
    a = (ex < 0 ? -ex : ex);
    a = a * a;
    b = (ey < 0 ? -ey : ey);
    b = b * b;
    es = a + b;
    ovf = es < a;
    if (shadow_cfg.mode == 1'b0) begin
      c = (ez < 0 ? -ez : ez);
      c = c * c;
      t = es + c;
      if (t < es) ovf = 1'b1;
      es = t;
    end
    res.vel_x      = vx[31:0];
    res.vel_y      = vy[31:0];
    res.vel_z      = vz[31:0];
    res.error_norm = ovf ? 32'hFFFF_FFFF : 32'(isqrt(es));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Registers change only once every request in flight has come out.
  task automatic write_reg(input pvc_cfg_idx_t idx, input logic [LIM_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE:        shadow_cfg.mode        = value[0];
      CFG_GAIN_XY:     shadow_cfg.gain_xy     = value[GAIN_W-1:0];
      CFG_SPEED_LIMIT: shadow_cfg.speed_limit = value;
      CFG_GAIN_Z:      shadow_cfg.gain_z      = value[GAIN_W-1:0];
      CFG_Z_LIMIT:     shadow_cfg.z_limit     = value;
      default: ;
    endcase
  endtask

  // Sends one request; the expectation is queued once the handshake completes.
  // Valid stays high after the handshake so the next request can follow at once.
  task automatic send_request(input pvc_in_t req);
    if (idle_enabled && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_cmds.push_back(predict_command(req));
    @(negedge clk);
  endtask

  // Stop sending, wait until every result has arrived, then let the pipeline drain.
  task automatic drain;
    if (in_valid) in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word;
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 400000)))
                                           : -32'(int'($urandom_range(0, 400000)));
      default: return $urandom;
    endcase
  endfunction

  function automatic pvc_in_t rand_request;
    pvc_in_t req;
    req.cur_x    = rand_word();
    req.cur_y    = rand_word();
    req.cur_z    = rand_word();
    // Small errors keep many commands below the speed limit.
    if ($urandom_range(0, 1)) begin
      req.target_x = req.cur_x + 32'(int'($urandom_range(0, 200000)) - 100000);
      req.target_y = req.cur_y + 32'(int'($urandom_range(0, 200000)) - 100000);
      req.target_z = req.cur_z + 32'(int'($urandom_range(0, 200000)) - 100000);
    end else begin
      req.target_x = rand_word();
      req.target_y = rand_word();
      req.target_z = rand_word();
    end
    return req;
  endfunction

  function automatic pvc_in_t make_request(input logic [31:0] cx, cy, cz, tx, ty, tz);
    pvc_in_t req;
    req.cur_x = cx; req.cur_y = cy; req.cur_z = cz;
    req.target_x = tx; req.target_y = ty; req.target_z = tz;
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking: every accepted result is compared with the oldest expectation.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, out_data);
        error_count++;
      end else begin
        pvc_out_t exp_cmd;
        exp_cmd = pending_cmds.pop_front();
        if (out_data.vel_x !== exp_cmd.vel_x) begin
          $display("%0t: vel_x expected %h actual %h", $time, exp_cmd.vel_x, out_data.vel_x);
          error_count++;
        end
        if (out_data.vel_y !== exp_cmd.vel_y) begin
          $display("%0t: vel_y expected %h actual %h", $time, exp_cmd.vel_y, out_data.vel_y);
          error_count++;
        end
        if (out_data.vel_z !== exp_cmd.vel_z) begin
          $display("%0t: vel_z expected %h actual %h", $time, exp_cmd.vel_z, out_data.vel_z);
          error_count++;
        end
        if (out_data.error_norm !== exp_cmd.error_norm) begin
          $display("%0t: error_norm expected %h actual %h", $time, exp_cmd.error_norm,
                   out_data.error_norm);
          error_count++;
        end
      end
    end
  end

  // Receiver: random stall bursts, or a long hold-off when one is requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end
      if (idle_enabled && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults, field extremes, zero error and overflow of the error norm.
  task automatic test_reset_defaults;
    send_request(make_request(0, 0, 0, 0, 0, 0));
    send_request(make_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_request(make_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_request(make_request(0, 0, 0, 32'h0000_4000, 32'hFFFF_C000, 32'h0001_0000));
    send_request(make_request(0, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    drain();
  endtask

  // Full 3D limiting with the largest gain and a limit of 0x400000, then a zero speed limit and a zero gain.
  task automatic test_mode_3d_limits;
    write_reg(CFG_MODE, 0);
    write_reg(CFG_GAIN_XY, 23'hFFFF);
    write_reg(CFG_SPEED_LIMIT, 23'h40_0000);
    send_request(make_request(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0100));
    send_request(make_request(0, 0, 0, 32'h0000_0100, 32'h0000_0000, 32'h0000_0000));
    send_request(make_request(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000));
    write_reg(CFG_SPEED_LIMIT, 0);
    send_request(make_request(0, 0, 0, 32'h0001_0000, 32'h0000_0000, 32'h0000_0001));
    send_request(make_request(0, 0, 0, 0, 0, 0));
    write_reg(CFG_GAIN_XY, 0);
    send_request(make_request(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    drain();
  endtask

  // XY limiting with a separate Z clamp, zero Z settings and the largest Z gain, and an
  // out-of-range register index that must be ignored.
  task automatic test_mode_xy_z_clamp;
    write_reg(CFG_MODE, 1);
    write_reg(CFG_GAIN_XY, 23'h0100);
    write_reg(CFG_SPEED_LIMIT, 23'h1_0000);
    write_reg(CFG_GAIN_Z, 23'hFFFF);
    write_reg(CFG_Z_LIMIT, 23'h40_0000);
    send_request(make_request(0, 0, 0, 32'h0003_0000, 32'h0004_0000, 32'h7FFF_FFFF));
    write_reg(CFG_Z_LIMIT, 0);
    send_request(make_request(0, 0, 0, 32'h0000_8000, 32'h0000_0000, 32'h8000_0000));
    write_reg(CFG_GAIN_Z, 0);
    write_reg(pvc_cfg_idx_t'(3'd5), 23'h7F_FFFF);
    write_reg(pvc_cfg_idx_t'(3'd7), 23'h00_0000);
    send_request(make_request(0, 0, 0, 32'h0000_8000, 32'h0000_0000, 32'h8000_0000));
    write_reg(CFG_GAIN_Z, 23'd384);
    write_reg(CFG_Z_LIMIT, 23'h1_0000);
    send_request(make_request(32'h7FFF_FFFF, 32'h8000_0000, 0,
                              32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0100));
    drain();
  endtask

  // Random requests over several register settings.
  task automatic test_random_settings(input int n_items);
    repeat (8) begin
      write_reg(CFG_MODE, LIM_W'($urandom_range(0, 1)));
      write_reg(CFG_GAIN_XY, LIM_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 16'hFFFF)
                                                             : $urandom_range(0, 2048)));
      write_reg(CFG_SPEED_LIMIT, LIM_W'($urandom_range(0, 23'h40_0000)));
      write_reg(CFG_GAIN_Z, LIM_W'($urandom_range(0, 16'hFFFF)));
      write_reg(CFG_Z_LIMIT, LIM_W'($urandom_range(0, 23'h40_0000)));
      repeat (n_items / 8) send_request(rand_request());
      drain();
    end
  endtask

  // The receiver holds off while requests keep coming, so the block backs up.
  task automatic test_backpressure;
    hold_off_cycles = 150;
    repeat (100) send_request(rand_request());
    drain();
  endtask

  // Back-to-back requests and a ready receiver with no idling.
  task automatic test_full_rate;
    idle_enabled = 1'b0;
    repeat (150) send_request(rand_request());
    drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    error_count  = 0;
    idle_enabled = 1'b1;
    hold_off_cycles = 0;
    shadow_cfg.mode        = MODE_RST;
    shadow_cfg.gain_xy     = GAIN_XY_RST;
    shadow_cfg.speed_limit = SPEED_LIMIT_RST;
    shadow_cfg.gain_z      = GAIN_Z_RST;
    shadow_cfg.z_limit     = Z_LIMIT_RST;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_mode_3d_limits();
    test_mode_xy_z_clamp();
    test_random_settings(1560);
    test_backpressure();
    test_full_rate();

    if (error_count == 0) begin
      $display("proportional_velocity_clamp verification clean");
    end else begin
      $display("proportional_velocity_clamp verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
